/* rtl/sdf_pkg.sv */
// sdf_pkg: types and constants of the serial packet deframer
// used by the interfaces, the deframer core, the output register and the checker
`default_nettype none

package sdf_pkg;

  localparam logic [7:0]  StartByte    = 8'h40;
  localparam logic [7:0]  LineFeed     = 8'h0A;
  localparam logic [15:0] TimeoutReset = 16'd3000;
  localparam logic [16:0] LenHiPos     = 17'd5;
  localparam logic [15:0] MinLength    = 16'd2;
  localparam logic [16:0] TailOffset   = 17'd5;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT_TICKS = 1'b0,
    CFG_LENGTH_BE     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SKIP = 2'd1,
    PH_HEAD = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADTAIL = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_SHORT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [16:0] byte_index;
    logic        last;
    status_e     status;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sdf_if.sv */
// sdf_in_if and sdf_out_if: valid/ready channels of the deframer
// depends on sdf_pkg for the status type
`default_nettype none

interface sdf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface sdf_out_if;
  import sdf_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [16:0] byte_index;
  logic        last;
  status_e     status;

  modport source (output valid, output data_byte, output byte_index, output last,
                  output status, input ready);
  modport sink (input valid, input data_byte, input byte_index, input last,
                input status, output ready);
endinterface

`default_nettype wire

/* rtl/serial_packet_deframer.sv */
// Serial packet deframer. Takes one transaction per clock (a received byte or a
// timer tick) and returns the packet bytes with their index in the next cycle from a
// result register; the input stays ready while that register is empty or being
// taken, so the rate is one item per cycle without output stalls. The framing
// state and tick counter update in the cycle of acceptance. Outside a packet the
// block hunts for 0x40, skipping to line feed after any other byte. A packet is
// the start byte, six header bytes with a 16-bit length in bytes 5 and 6,
// length-2 body bytes and a tail marked last. Timeouts and a length below 2 end
// the packet with status 2 or 3. Register 0 is the tick budget of one read
// phase, register 1 selects big-endian length.
`default_nettype none

module serial_packet_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sdf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sdf_pkg::CfgDataW-1:0]  cfg_data_i,
  sdf_in_if.sink                             in_i,
  sdf_out_if.source                          out_o
);
  import sdf_pkg::*;

  logic    fire;
  logic    load_ok;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_i.ready = load_ok;
  assign fire       = in_i.valid && load_ok;

  sdf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .kind_i      (in_i.kind),
    .rx_byte_i   (in_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid && fire),
    .res_i       (res),
    .load_ok_o   (load_ok),
    .out_valid_o (out_o.valid),
    .out_o       (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.data_byte  = out_res.data_byte;
  assign out_o.byte_index = out_res.byte_index;
  assign out_o.last       = out_res.last;
  assign out_o.status     = out_res.status;

endmodule

`default_nettype wire

/* rtl/sdf_core.sv */
// sdf_core: framing state, tick counter and configuration registers
// produces at most one result per accepted transaction; depends on sdf_pkg
`default_nettype none

module sdf_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sdf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sdf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          fire_i,
  input  wire logic                          kind_i,
  input  wire logic [7:0]                    rx_byte_i,
  output      logic                          res_valid_o,
  output      sdf_pkg::result_t              res_o
);
  import sdf_pkg::*;

  logic [15:0] timeout_q;
  logic        len_be_q;
  phase_e      phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] tick_inc;
  logic [15:0] len_new;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      len_be_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i;
        CFG_LENGTH_BE:     len_be_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      len_q   <= '0;
      first_q <= '0;
      tick_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      first_q <= first_d;
      tick_q  <= tick_d;
    end
  end

  // saturating tick count
  assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign len_new  = len_be_q ? {first_q, rx_byte_i} : {rx_byte_i, first_q};

  always_comb begin
    phase_d         = phase_q;
    pos_d           = pos_q;
    len_d           = len_q;
    first_d         = first_q;
    tick_d          = tick_q;
    res_valid_o     = 1'b0;
    res_o.data_byte  = rx_byte_i;
    res_o.byte_index = pos_q;
    res_o.last       = 1'b0;
    res_o.status     = ST_OK;

    if (kind_i) begin
      tick_d = tick_inc;
      if (tick_inc >= timeout_q) begin
        if (phase_q == PH_HEAD || phase_q == PH_BODY) begin
          res_valid_o     = 1'b1;
          res_o.data_byte = 8'h00;
          res_o.last      = 1'b1;
          res_o.status    = ST_TIMEOUT;
        end
        phase_d = PH_HUNT;
        pos_d   = '0;
        tick_d  = '0;
      end
    end else begin
      case (phase_q)
        PH_HEAD: begin
          res_valid_o = 1'b1;
          pos_d       = pos_q + 17'd1;
          if (pos_q == LenHiPos) begin
            first_d = rx_byte_i;
          end else if (pos_q == LenHiPos + 17'd1) begin
            len_d = len_new;
            if (len_new < MinLength) begin
              res_o.last   = 1'b1;
              res_o.status = ST_SHORT;
              phase_d      = PH_HUNT;
              pos_d        = '0;
              tick_d       = '0;
            end else begin
              phase_d = PH_BODY;
              tick_d  = '0;
            end
          end
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          if (pos_q >= {1'b0, len_q} + TailOffset) begin
            res_o.last   = 1'b1;
            res_o.status = (rx_byte_i == LineFeed) ? ST_OK : ST_BADTAIL;
            phase_d      = PH_HUNT;
            pos_d        = '0;
            tick_d       = '0;
          end else begin
            pos_d = pos_q + 17'd1;
          end
        end
        PH_SKIP: begin
          tick_d = '0;
          if (rx_byte_i == LineFeed) phase_d = PH_HUNT;
        end
        default: begin
          tick_d = '0;
          if (rx_byte_i == StartByte) begin
            res_valid_o      = 1'b1;
            res_o.byte_index = '0;
            phase_d          = PH_HEAD;
            pos_d            = 17'd1;
          end else if (rx_byte_i != LineFeed) begin
            phase_d = PH_SKIP;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sdf_out_reg.sv */
// sdf_out_reg: result register between the core and the output channel
// loads whenever it is empty or being drained; depends on sdf_pkg
`default_nettype none

module sdf_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire sdf_pkg::result_t res_i,
  output      logic             load_ok_o,
  output      logic             out_valid_o,
  output      sdf_pkg::result_t out_o,
  input  wire logic             out_ready_i
);
  import sdf_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign load_ok_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && res_valid_i) data_q <= res_i;
  end

endmodule

`default_nettype wire

/* rtl/sdf_checker.sv */
// sdf_checker: port-level assertions on the deframer result channel
// bound to serial_packet_deframer; depends on sdf_pkg
`default_nettype none

module sdf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  data_byte_i,
  input wire logic [16:0] byte_index_i,
  input wire logic        last_i,
  input wire logic [1:0]  status_i
);
  import sdf_pkg::*;

  // a stalled transaction keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_byte_i)
      && $stable(byte_index_i) && $stable(last_i) && $stable(status_i))
    else $error("result changed while stalled");

  // any non-ok status ends the packet
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> last_i)
    else $error("error status without last");

  // index zero is always the start byte, never an end
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_index_i == 17'd0 |->
      data_byte_i == StartByte && !last_i && status_i == ST_OK)
    else $error("bad start result");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i != ST_TIMEOUT || data_byte_i == 8'h00)
      && (status_i != ST_BADTAIL || data_byte_i != LineFeed))
    else $error("data inconsistent with status");

endmodule

bind serial_packet_deframer sdf_checker u_sdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .data_byte_i  (out_o.data_byte),
  .byte_index_i (out_o.byte_index),
  .last_i       (out_o.last),
  .status_i     (out_o.status)
);

`default_nettype wire
